[src/rfog_pkg.sv]
// ----------------------------------------------------------------------------
// Rectangle fit occupancy grid package
// Shared constants, action and result codes, sequencer states and the
// request bundle that the sequencer hands to the fit checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfog_pkg;

    // Largest grid side the storage is built for.
    localparam int MAX_SIDE_DEF = 8;

    // Width of the side register and of rectangle extents.
    localparam int SIDE_W = 4;

    // Coordinate width fixed by the beat layout.
    localparam int COORD_W = 3;

    // Label held by a free cell: the '*' character.
    localparam logic [7:0] FREE_LABEL = 8'd42;

    // Reset value of the side register.
    localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd8;

    // Input action codes.
    localparam logic [2:0] ACT_SET   = 3'd0;
    localparam logic [2:0] ACT_CLEAR = 3'd1;
    localparam logic [2:0] ACT_READ  = 3'd2;
    localparam logic [2:0] ACT_FIND  = 3'd3;
    localparam logic [2:0] ACT_FULL  = 3'd4;

    // Result kind codes.
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_FIT   = 2'd1;
    localparam logic [1:0] KIND_NOFIT = 2'd2;
    localparam logic [1:0] KIND_FULL  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCAN,
        ST_DONE
    } state_t;

    // One candidate position to test against the grid.
    typedef struct packed {
        logic [COORD_W-1:0] cand_x;
        logic [COORD_W-1:0] cand_y;
        logic [SIDE_W-1:0]  len;
        logic [SIDE_W-1:0]  wid;
        logic [SIDE_W-1:0]  side;
    } fit_req_t;

endpackage : rfog_pkg

`default_nettype wire

[src/rfog_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfog_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : rfog_ram

`default_nettype wire

[src/rfog_fit.sv]
// ----------------------------------------------------------------------------
// Rectangle fit checker
// Tests one candidate top-left cell combinationally: the cell must be free, the
// rectangle must lie inside the active side and cover only free cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfog_fit #(
    parameter int MAX_SIDE = rfog_pkg::MAX_SIDE_DEF
) (
    input  wire logic [MAX_SIDE*MAX_SIDE-1:0] occ,
    input  wire rfog_pkg::fit_req_t           req,
    output logic                              fit
);

    import rfog_pkg::*;

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [SIDE_W:0] x_end;
    logic [SIDE_W:0] y_end;
    logic            blocked;
    logic [CW-1:0]   own_idx;

    always_comb
    begin
        x_end   = {2'b00, req.cand_x} + {1'b0, req.len};
        y_end   = {2'b00, req.cand_y} + {1'b0, req.wid};
        own_idx = CW'(int'(req.cand_x) * MAX_SIDE + int'(req.cand_y));
        blocked = 1'b0;
        // Every covered cell is checked in parallel; the rows are independent.
        for (int r = 0; r < MAX_SIDE; r++)
        begin
            for (int c = 0; c < MAX_SIDE; c++)
            begin
                if ((5'(r) >= {2'b00, req.cand_x}) && (5'(r) < x_end) &&
                    (5'(c) >= {2'b00, req.cand_y}) && (5'(c) < y_end))
                begin
                    blocked = blocked | occ[r * MAX_SIDE + c];
                end
            end
        end
        fit = !occ[own_idx] && !blocked &&
              (x_end <= {1'b0, req.side}) && (y_end <= {1'b0, req.side});
    end

endmodule : rfog_fit

`default_nettype wire

[src/rectangle_fit_occupancy_grid_top.sv]
// ----------------------------------------------------------------------------
// Rectangle fit occupancy grid, top level
// Square grid of occupied bits with an 8-bit label per cell. Sets, clears and
// reads single cells, answers whether the active grid is full, and lists
// every top-left cell where a rectangle fits.
//
//   Channel  Direction  Handshake                    Carries
//   s_axis   in         s_axis_tvalid/s_axis_tready  one action beat
//   m_axis   out        m_axis_tvalid/m_axis_tready  result beats, tlast ends
//   cfg      in         cfg_we (no back-pressure)    active side length
//
// Set, clear and unknown actions are decoded and done with no result beat.
// A read goes through the decode and read states, waiting on the registered
// label memory. A fit search or full query sweeps every active candidate
// cell through the one fit checker, one cell per cycle unless a second fit
// must wait for room in the output register. The block accepts a new beat
// only when the previous one is done.
// Reset leaves all cells free with label '*' and the side set to eight; the
// labels are cleared through per-cell valid bits, so no clearing pass runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rectangle_fit_occupancy_grid_top #(
    parameter int MAX_SIDE = rfog_pkg::MAX_SIDE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Configuration: active side length.
    input  wire logic                        cfg_we,
    input  wire logic [rfog_pkg::SIDE_W-1:0] cfg_wdata,
    // Input stream.
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // From bit 0: x[2:0], y[5:3], piece[13:6], rect_length[17:14],
    // rect_width[21:18], rect_placed[22], zero pad[23].
    input  wire logic [23:0]                 s_axis_tdata,
    // action[2:0]
    input  wire logic [2:0]                  s_axis_tuser,
    // Output stream.
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // From bit 0: out_x[2:0], out_y[5:3], occupied[6], piece_out[14:7],
    // full_res[15].
    output logic      [15:0]                 m_axis_tdata,
    // kind[1:0]
    output logic      [1:0]                  m_axis_tuser,
    output logic                             m_axis_tlast
);

    import rfog_pkg::*;

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    // Configuration register and the side actually in use.
    logic [SIDE_W-1:0] side_reg;
    logic [SIDE_W-1:0] side_act;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
        end
        else if (cfg_we)
        begin
            side_reg <= cfg_wdata;
        end
    end

    assign side_act = (side_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side_reg;

    // The accepted beat is held for the whole action.
    logic [2:0]         act_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [7:0]         piece_reg;
    logic [SIDE_W-1:0]  len_reg;
    logic [SIDE_W-1:0]  wid_reg;
    logic               placed_reg;

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            act_reg    <= s_axis_tuser;
            x_reg      <= s_axis_tdata[2:0];
            y_reg      <= s_axis_tdata[5:3];
            piece_reg  <= s_axis_tdata[13:6];
            len_reg    <= s_axis_tdata[17:14];
            wid_reg    <= s_axis_tdata[21:18];
            placed_reg <= s_axis_tdata[22];
        end
    end

    // Sequencer and grid state.
    state_t             state_reg,    state_next;
    logic [CELLS-1:0]   occ_reg,      occ_next;
    logic [CELLS-1:0]   lbl_vld_reg,  lbl_vld_next;
    logic [COORD_W-1:0] cx_reg,       cx_next;
    logic [COORD_W-1:0] cy_reg,       cy_next;
    logic [COORD_W-1:0] pend_x_reg,   pend_x_next;
    logic [COORD_W-1:0] pend_y_reg,   pend_y_next;
    logic               pend_vld_reg, pend_vld_next;
    logic               any_free_reg, any_free_next;
    logic               rd_ok_reg,    rd_ok_next;
    logic               rd_occ_reg,   rd_occ_next;

    // Output register.
    logic               out_vld_reg,  out_vld_next;
    logic [1:0]         out_kind_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic               out_occ_reg;
    logic [7:0]         out_piece_reg;
    logic               out_full_reg;
    logic               out_last_reg;

    // Result about to be loaded into the output register.
    logic               emit;
    logic [1:0]         e_kind;
    logic [COORD_W-1:0] e_x;
    logic [COORD_W-1:0] e_y;
    logic               e_occ;
    logic [7:0]         e_piece;
    logic               e_full;
    logic               e_last;

    logic               out_free;
    logic [CW-1:0]      cell_idx;
    logic               in_side;
    logic               in_max;
    logic               is_find;
    logic               step;
    logic               fit;
    fit_req_t           fit_req;

    // Label memory and its ports.
    logic               ram_we;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [7:0]         ram_rdata;

    rfog_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_labels (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cell_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cell_idx),
        .rdata (ram_rdata)
    );

    // The fit checker serves both the fit search and the full query; for the
    // latter a one-by-one rectangle fits exactly where a cell is free.
    assign is_find = (act_reg == ACT_FIND);

    always_comb
    begin
        fit_req.cand_x = cx_reg;
        fit_req.cand_y = cy_reg;
        fit_req.len    = is_find ? len_reg : SIDE_W'(1);
        fit_req.wid    = is_find ? wid_reg : SIDE_W'(1);
        fit_req.side   = side_act;
    end

    rfog_fit #(
        .MAX_SIDE (MAX_SIDE)
    ) u_fit (
        .occ (occ_reg),
        .req (fit_req),
        .fit (fit)
    );

    assign cell_idx = CW'(int'(x_reg) * MAX_SIDE + int'(y_reg));
    assign in_side  = ({1'b0, x_reg} < side_act) && ({1'b0, y_reg} < side_act);
    assign in_max   = ({1'b0, x_reg} < SIDE_W'(MAX_SIDE)) &&
                      ({1'b0, y_reg} < SIDE_W'(MAX_SIDE));
    assign out_free = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            lbl_vld_reg  <= '0;
            pend_vld_reg <= 1'b0;
            any_free_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            lbl_vld_reg  <= lbl_vld_next;
            pend_vld_reg <= pend_vld_next;
            any_free_reg <= any_free_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        pend_x_reg <= pend_x_next;
        pend_y_reg <= pend_y_next;
        rd_ok_reg  <= rd_ok_next;
        rd_occ_reg <= rd_occ_next;
        if (emit)
        begin
            out_kind_reg  <= e_kind;
            out_x_reg     <= e_x;
            out_y_reg     <= e_y;
            out_occ_reg   <= e_occ;
            out_piece_reg <= e_piece;
            out_full_reg  <= e_full;
            out_last_reg  <= e_last;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        lbl_vld_next  = lbl_vld_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        pend_x_next   = pend_x_reg;
        pend_y_next   = pend_y_reg;
        pend_vld_next = pend_vld_reg;
        any_free_next = any_free_reg;
        rd_ok_next    = rd_ok_reg;
        rd_occ_next   = rd_occ_reg;
        ram_we        = 1'b0;
        ram_wdata     = FREE_LABEL;
        ram_re        = 1'b0;
        step          = 1'b0;
        emit          = 1'b0;
        e_kind        = KIND_READ;
        e_x           = '0;
        e_y           = '0;
        e_occ         = 1'b0;
        e_piece       = '0;
        e_full        = 1'b0;
        e_last        = 1'b1;
        s_axis_tready = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                unique case (act_reg) inside
                    ACT_SET, ACT_CLEAR:
                    begin
                        // Cells outside the active side are left alone.
                        if (in_side)
                        begin
                            occ_next[cell_idx]     = (act_reg == ACT_SET);
                            lbl_vld_next[cell_idx] = 1'b1;
                            ram_we                 = 1'b1;
                            ram_wdata = (act_reg == ACT_SET) ? piece_reg : FREE_LABEL;
                        end
                        state_next = ST_IDLE;
                    end

                    ACT_READ:
                    begin
                        ram_re      = in_max;
                        rd_ok_next  = in_max && lbl_vld_reg[cell_idx];
                        rd_occ_next = in_max && occ_reg[cell_idx];
                        state_next  = ST_READ;
                    end

                    ACT_FIND, ACT_FULL:
                    begin
                        cx_next       = '0;
                        cy_next       = '0;
                        pend_vld_next = 1'b0;
                        any_free_next = 1'b0;
                        // A placed rectangle or a side of zero has nothing to sweep.
                        if ((is_find && placed_reg) || (side_act == '0))
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_READ:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_READ;
                    e_x        = x_reg;
                    e_y        = y_reg;
                    e_occ      = rd_occ_reg;
                    e_piece    = rd_ok_reg ? ram_rdata : FREE_LABEL;
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // A fit found while one is already pending pushes the pending
                // one out, so that needs room in the output register.
                step = !(is_find && fit && pend_vld_reg) || out_free;
                if (step)
                begin
                    if (is_find && fit)
                    begin
                        if (pend_vld_reg)
                        begin
                            emit   = 1'b1;
                            e_kind = KIND_FIT;
                            e_x    = pend_x_reg;
                            e_y    = pend_y_reg;
                            e_last = 1'b0;
                        end
                        pend_x_next   = cx_reg;
                        pend_y_next   = cy_reg;
                        pend_vld_next = 1'b1;
                    end
                    if (!is_find && fit)
                    begin
                        any_free_next = 1'b1;
                    end
                    if (({1'b0, cy_reg} + SIDE_W'(1)) == side_act)
                    begin
                        cy_next = '0;
                        if (({1'b0, cx_reg} + SIDE_W'(1)) == side_act)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cx_next = cx_reg + COORD_W'(1);
                        end
                    end
                    else
                    begin
                        cy_next = cy_reg + COORD_W'(1);
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (!is_find)
                    begin
                        e_kind = KIND_FULL;
                        e_full = !any_free_reg;
                    end
                    else if (pend_vld_reg)
                    begin
                        e_kind = KIND_FIT;
                        e_x    = pend_x_reg;
                        e_y    = pend_y_reg;
                    end
                    else
                    begin
                        e_kind = KIND_NOFIT;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {out_full_reg, out_piece_reg, out_occ_reg, out_y_reg, out_x_reg};

    // Only a fit position may be followed by further beats of the same item.
    a_single_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_READ || m_axis_tuser == KIND_NOFIT ||
                           m_axis_tuser == KIND_FULL)) |-> m_axis_tlast)
        else $error("single-result beat without tlast");

    // An accepted beat is always decoded in the following cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted beat not decoded");

    // The sweep never leaves the active side.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |->
            (({1'b0, cx_reg} < side_act) && ({1'b0, cy_reg} < side_act)))
        else $error("candidate outside the active side");

    // A fit beat that does not end the list always leaves another fit pending.
    a_fit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_FIT) && !m_axis_tlast) |-> pend_vld_reg)
        else $error("open fit list with nothing pending");

endmodule : rectangle_fit_occupancy_grid_top

`default_nettype wire
